/* src/ordered_list_insert_remove_engine_top_macros.svh */
// Assertion macros shared by the ordered list engine modules.
// Each macro expects clk_i and rst_ni to be visible in the calling module.
`ifndef ORDERED_LIST_INSERT_REMOVE_ENGINE_TOP_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_ENGINE_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define OLIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition never occurs outside reset.
`define OLIE_ASSERT_NEVER(lbl, expr, msg) \
  `OLIE_ASSERT(lbl, !(expr), msg)

`endif

/* src/olie_pkg.sv */
// Package for the ordered list engine: sizes, operation codes, FSM states
// and the command struct between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package olie_pkg;

  localparam int DEPTH    = 64;
  localparam int HANDLE_W = 16;
  localparam int KEY_W    = 32;
  localparam int MODE_W   = 3;
  localparam int POS_W    = 6;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = IDX_W;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(DEPTH - 1);

  localparam int IN_FIELDS_W  = MODE_W + POS_W + HANDLE_W + KEY_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + HANDLE_W + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_INSERT     = 3'd1,
    OP_FIND       = 3'd2,
    OP_READ       = 3'd3,
    OP_REMOVE_KEY = 3'd4,
    OP_REMOVE_POS = 3'd5,
    OP_COUNT      = 3'd6
  } op_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;  // latch the operation and register the key matches
    logic execute;  // apply the operation and load the result register
  } olie_cmd_t;

endpackage

/* src/ordered_list_insert_remove_engine_top.sv */
// Top level of the ordered list engine: stream ports, field packing, and
// the controller and datapath. Depends on olie_pkg, olie_ctrl, olie_datapath.
`timescale 1ns / 1ps

// Usage:
// The block keeps an ordered list of up to 63 entries, each a 16-bit handle
// and a 32-bit key. Each transfer on the slave stream carries one operation:
// append, insert at a position, find by key, read at a position, remove by
// key, remove at a position, or count. Each operation returns exactly one
// transfer on the master stream with ok, the handle read or removed (zero
// when none), and the entry count after the operation.
// On acceptance, the key is compared against every entry cell at once and
// the accepting edge registers the operation and the matches; in the
// execute state, once the result register has room, the block picks the
// first match or the position, shifts the cells and loads the result
// register, and the result then appears on the master side.
// The two-state sequencer that owns the cell row takes no new operation
// until the current one has executed. A new transfer is accepted while an
// earlier result still waits in the output register. When the receiver
// stalls, the block holds in its execute state until the result register
// drains, and the list is not changed until then.
// Reset empties the list at once; the entry cells themselves are not
// cleared, and only cells below the count are ever read.

module ordered_list_insert_remove_engine_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // mode[2:0], position[8:3], entry_handle[24:9], entry_key[56:25], zero pad
  input  logic [olie_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // ok[0], found_handle[16:1], entry_count[22:17], zero pad
  output logic [olie_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import olie_pkg::*;

  localparam int PosLo    = MODE_W;
  localparam int HandleLo = PosLo + POS_W;
  localparam int KeyLo    = HandleLo + HANDLE_W;

  olie_cmd_t           cmd;
  logic [MODE_W-1:0]   in_mode;
  logic [POS_W-1:0]    in_position;
  logic [HANDLE_W-1:0] in_handle;
  logic [KEY_W-1:0]    in_key;
  logic                res_ok;
  logic [HANDLE_W-1:0] res_handle;
  logic [CNT_W-1:0]    res_count;

  assign in_mode     = s_axis_tdata[MODE_W-1:0];
  assign in_position = s_axis_tdata[PosLo +: POS_W];
  assign in_handle   = s_axis_tdata[HandleLo +: HANDLE_W];
  assign in_key      = s_axis_tdata[KeyLo +: KEY_W];

  olie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  olie_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (in_mode),
    .position_i     (in_position),
    .entry_handle_i (in_handle),
    .entry_key_i    (in_key),
    .ok_o           (res_ok),
    .found_handle_o (res_handle),
    .entry_count_o  (res_count)
  );

  assign m_axis_tdata = OUT_TDATA_W'({res_count, res_handle, res_ok});

endmodule

/* src/olie_ctrl.sv */
// Controller of the ordered list engine: two-state sequencer and the
// result valid flag. Depends on olie_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ordered_list_insert_remove_engine_top_macros.svh"

module olie_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output olie_pkg::olie_cmd_t cmd_o
);
  import olie_pkg::*;

  state_e state_q, state_d;
  logic   m_tvalid_q, m_tvalid_d;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !m_tvalid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.execute = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (cmd_o.execute) begin
      m_tvalid_d = 1'b1;
    end else if (out_ready_i) begin
      m_tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  assign out_valid_o = m_tvalid_q;

  `OLIE_ASSERT(a_capture_then_exec, cmd_o.capture |=> state_q == S_EXEC,
               "capture not followed by execute state")
  `OLIE_ASSERT(a_exec_needs_room, cmd_o.execute |-> (!m_tvalid_q || out_ready_i),
               "result overwritten before it was taken")
  `OLIE_ASSERT(a_exec_gives_result, cmd_o.execute |=> m_tvalid_q,
               "execute did not present a result")

endmodule

/* src/olie_datapath.sv */
// Datapath of the ordered list engine: a row of entry cells that shift
// and compare in parallel, the count, and the result register. Uses olie_pkg.
`timescale 1ns / 1ps
`include "ordered_list_insert_remove_engine_top_macros.svh"

module olie_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  olie_pkg::olie_cmd_t           cmd_i,
  input  logic [olie_pkg::MODE_W-1:0]   mode_i,
  input  logic [olie_pkg::POS_W-1:0]    position_i,
  input  logic [olie_pkg::HANDLE_W-1:0] entry_handle_i,
  input  logic [olie_pkg::KEY_W-1:0]    entry_key_i,
  output logic                          ok_o,
  output logic [olie_pkg::HANDLE_W-1:0] found_handle_o,
  output logic [olie_pkg::CNT_W-1:0]    entry_count_o
);
  import olie_pkg::*;

  // Entry cells. Only cells below the count are ever read.
  logic [HANDLE_W-1:0] cell_handle_q [DEPTH];
  logic [KEY_W-1:0]    cell_key_q    [DEPTH];
  logic [CNT_W-1:0]    count_q, count_d;

  // Operation captured in the first cycle.
  logic [MODE_W-1:0]   mode_q;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [HANDLE_W-1:0] handle_in_q;
  logic [KEY_W-1:0]    key_in_q;
  logic [DEPTH-1:0]    eq_q, eq_d;

  // Result register.
  logic                ok_q;
  logic [HANDLE_W-1:0] found_q;
  logic [CNT_W-1:0]    res_count_q;

  // Execute-cycle decode.
  logic                key_mode, hit, full, pos_lt, pos_le;
  logic                ok_d, do_insert, do_remove, returns_handle;
  logic [DEPTH-1:0]    ge_key, ge_pos, ge, sel;
  logic [HANDLE_W-1:0] got;

  // Key matches against every held entry, registered for the execute state.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eq_d[i] = (cell_key_q[i] == entry_key_i) && (IDX_W'(i) < count_q);
    end
  end

  // An append is an insert at the current end of the list.
  assign pos_d = (mode_i == OP_APPEND) ? count_q : IDX_W'(position_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q      <= mode_i;
      pos_q       <= pos_d;
      handle_in_q <= entry_handle_i;
      key_in_q    <= entry_key_i;
      eq_q        <= eq_d;
    end
  end

  assign key_mode = (mode_q == OP_FIND) || (mode_q == OP_REMOVE_KEY);
  assign hit      = |eq_q;
  assign full     = count_q >= MAX_CNT;
  assign pos_lt   = pos_q < count_q;
  assign pos_le   = pos_q <= count_q;

  // Cells at or above the first match: the lowest set bit and all above it.
  assign ge_key = eq_q | ((~eq_q) + DEPTH'(1));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge_pos[i] = IDX_W'(i) >= pos_q;
    end
  end

  assign ge  = key_mode ? ge_key : ge_pos;
  assign sel = ge & ~(ge << 1);

  always_comb begin
    got = '0;
    for (int i = 0; i < DEPTH; i++) begin
      got = got | (cell_handle_q[i] & {HANDLE_W{sel[i]}});
    end
  end

  always_comb begin
    ok_d           = 1'b0;
    do_insert      = 1'b0;
    do_remove      = 1'b0;
    returns_handle = 1'b0;
    unique case (mode_q)
      OP_APPEND, OP_INSERT: begin
        do_insert = !full && pos_le;
        ok_d      = do_insert;
      end
      OP_FIND: begin
        ok_d           = hit;
        returns_handle = 1'b1;
      end
      OP_READ: begin
        ok_d           = pos_lt;
        returns_handle = 1'b1;
      end
      OP_REMOVE_KEY: begin
        do_remove      = hit;
        ok_d           = hit;
        returns_handle = 1'b1;
      end
      OP_REMOVE_POS: begin
        do_remove      = pos_lt;
        ok_d           = pos_lt;
        returns_handle = 1'b1;
      end
      OP_COUNT: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_remove) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      ok_q        <= ok_d;
      found_q     <= (ok_d && returns_handle) ? got : '0;
      res_count_q <= count_d;
    end
  end

  // Each cell loads the new entry, its lower neighbor on insert, or its
  // upper neighbor on remove.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [HANDLE_W-1:0] below_h, above_h;
    logic [KEY_W-1:0]    below_k, above_k;

    if (g == 0) begin : g_first
      assign below_h = handle_in_q;
      assign below_k = key_in_q;
    end else begin : g_inner_lo
      assign below_h = cell_handle_q[g-1];
      assign below_k = cell_key_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign above_h = cell_handle_q[g];
      assign above_k = cell_key_q[g];
    end else begin : g_inner_hi
      assign above_h = cell_handle_q[g+1];
      assign above_k = cell_key_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.execute) begin
        if (do_insert && sel[g]) begin
          cell_handle_q[g] <= handle_in_q;
          cell_key_q[g]    <= key_in_q;
        end else if (do_insert && ge[g]) begin
          cell_handle_q[g] <= below_h;
          cell_key_q[g]    <= below_k;
        end else if (do_remove && ge[g]) begin
          cell_handle_q[g] <= above_h;
          cell_key_q[g]    <= above_k;
        end
      end
    end
  end

  assign ok_o           = ok_q;
  assign found_handle_o = found_q;
  assign entry_count_o  = res_count_q;

  `OLIE_ASSERT(a_count_bound, count_q <= MAX_CNT, "entry count above capacity")
  `OLIE_ASSERT(a_count_idle, !cmd_i.execute |=> $stable(count_q),
               "entry count changed outside execute")
  `OLIE_ASSERT(a_count_fail, (cmd_i.execute && !ok_d) |=> $stable(count_q),
               "failed operation changed the entry count")

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the ordered list engine: a directed table, then
// random operation mixes under idle and stall phases. Depends on olie_pkg.
`timescale 1ns / 1ps

module tb_top;
  import olie_pkg::*;

  localparam logic [MODE_W-1:0] OP_UNUSED  = 3'd7;
  localparam int                IDLE_LIMIT = 2000;
  localparam int                DRAIN_WAIT = 20;
  localparam int                SEG_ITEMS  = 85;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] handle;
    logic [CNT_W-1:0]    count;
  } list_result_t;

  // One directed operation; when typed is set, ok/fh/cnt hold the answer.
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [POS_W-1:0]    pos;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
    logic                typed;
    logic                ok;
    logic [HANDLE_W-1:0] fh;
    logic [CNT_W-1:0]    cnt;
  } op_row_t;

  localparam int DIR_N = 24;

  op_row_t op_table [0:DIR_N-1] = '{
    '{OP_COUNT,      6'd0,  16'h0000, 32'h0000_0000, 1'b1, 1'b1, 16'h0000, 6'd0},
    '{OP_READ,       6'd0,  16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 6'd0},
    '{OP_REMOVE_POS, 6'd0,  16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 6'd0},
    '{OP_FIND,       6'd0,  16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 6'd0},
    '{OP_REMOVE_KEY, 6'd0,  16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 6'd0},
    '{OP_INSERT,     6'd1,  16'h0001, 32'h0000_0001, 1'b1, 1'b0, 16'h0000, 6'd0},
    '{OP_UNUSED,     6'd0,  16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 6'd0},
    '{OP_APPEND,     6'd0,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'h0000, 6'd1},
    '{OP_INSERT,     6'd0,  16'h0000, 32'h0000_0000, 1'b1, 1'b1, 16'h0000, 6'd2},
    '{OP_INSERT,     6'd2,  16'h1234, 32'h0000_0000, 1'b1, 1'b1, 16'h0000, 6'd3},
    '{OP_INSERT,     6'd63, 16'h5555, 32'h0000_0005, 1'b1, 1'b0, 16'h0000, 6'd3},
    '{OP_FIND,       6'd0,  16'h0000, 32'h0000_0000, 1'b1, 1'b1, 16'h0000, 6'd3},
    '{OP_READ,       6'd63, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 6'd3},
    '{OP_READ,       6'd2,  16'h0000, 32'h0000_0000, 1'b1, 1'b1, 16'h1234, 6'd3},
    '{OP_READ,       6'd3,  16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 6'd3},
    '{OP_INSERT,     6'd1,  16'hAAAA, 32'h5A5A_5A5A, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{OP_READ,       6'd1,  16'h0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{OP_FIND,       6'd0,  16'h0000, 32'h1234_5678, 1'b1, 1'b0, 16'h0000, 6'd4},
    '{OP_REMOVE_POS, 6'd0,  16'h0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{OP_FIND,       6'd0,  16'h0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{OP_REMOVE_KEY, 6'd0,  16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{OP_REMOVE_POS, 6'd2,  16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 6'd2},
    '{OP_UNUSED,     6'd63, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0000, 6'd2},
    '{OP_COUNT,      6'd0,  16'h0000, 32'h0000_0000, 1'b1, 1'b1, 16'h0000, 6'd2}
  };

  // Cumulative percent cuts per mix (fill, balanced, drain) and their modes;
  // anything above the last cut is a count.
  int unsigned mix_cut [0:2][0:6] = '{
    '{2, 45, 80, 85, 90, 93, 96},
    '{2, 20, 35, 50, 65, 78, 91},
    '{2,  8, 14, 26, 38, 68, 94}
  };
  logic [MODE_W-1:0] mix_op [0:6] = '{
    OP_UNUSED, OP_APPEND, OP_INSERT, OP_FIND, OP_READ, OP_REMOVE_KEY, OP_REMOVE_POS
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Predictor state: the list as the block should hold it.
  logic [HANDLE_W-1:0] list_handle [0:DEPTH-1];
  logic [KEY_W-1:0]    list_key    [0:DEPTH-1];
  int                  list_len = 0;

  list_result_t pending_results [$];
  int unsigned  accept_cnt = 0;
  int unsigned  err_cnt = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  snk_stall_pct = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  ordered_list_insert_remove_engine_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  // Index of the first held entry with this key, or list_len if none.
  function automatic int find_first(logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < list_len; i++) begin
      if (list_key[i] == key) return i;
    end
    return list_len;
  endfunction

  function automatic void put_entry(int pos, logic [HANDLE_W-1:0] h, logic [KEY_W-1:0] k);
    int i;
    for (i = list_len; i > pos; i--) begin
      list_handle[i] = list_handle[i-1];
      list_key[i]    = list_key[i-1];
    end
    list_handle[pos] = h;
    list_key[pos]    = k;
    list_len++;
  endfunction

  function automatic logic [HANDLE_W-1:0] take_entry(int pos);
    logic [HANDLE_W-1:0] h;
    int                  i;
    h = list_handle[pos];
    for (i = pos; i + 1 < list_len; i++) begin
      list_handle[i] = list_handle[i+1];
      list_key[i]    = list_key[i+1];
    end
    list_len--;
    return h;
  endfunction

  function automatic list_result_t apply_list_op(logic [MODE_W-1:0] op, logic [POS_W-1:0] pos,
                                                 logic [HANDLE_W-1:0] h, logic [KEY_W-1:0] k);
    list_result_t res;
    bit           full;
    int           idx;
    res  = '0;
    full = (list_len >= DEPTH - 1);
    case (op)
      OP_APPEND: begin
        if (!full) begin
          put_entry(list_len, h, k);
          res.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (!full && pos <= list_len) begin
          put_entry(pos, h, k);
          res.ok = 1'b1;
        end
      end
      OP_FIND: begin
        idx = find_first(k);
        if (idx < list_len) begin
          res.handle = list_handle[idx];
          res.ok     = 1'b1;
        end
      end
      OP_READ: begin
        if (pos < list_len) begin
          res.handle = list_handle[pos];
          res.ok     = 1'b1;
        end
      end
      OP_REMOVE_KEY: begin
        idx = find_first(k);
        if (idx < list_len) begin
          res.handle = take_entry(idx);
          res.ok     = 1'b1;
        end
      end
      OP_REMOVE_POS: begin
        if (pos < list_len) begin
          res.handle = take_entry(pos);
          res.ok     = 1'b1;
        end
      end
      OP_COUNT: res.ok = 1'b1;
      default: ;
    endcase
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  // Random operation; positions and keys lean toward what the list holds.
  function automatic logic [IN_TDATA_W-1:0] make_random_op(int mix);
    logic [MODE_W-1:0]   op;
    logic [POS_W-1:0]    pos;
    logic [HANDLE_W-1:0] h;
    logic [KEY_W-1:0]    k;
    int unsigned         r;
    int                  i;
    r  = $urandom_range(99);
    op = OP_COUNT;
    for (i = 6; i >= 0; i--) begin
      if (r < mix_cut[mix][i]) op = mix_op[i];
    end
    if ($urandom_range(4) == 0) pos = POS_W'($urandom_range(63));
    else if (op == OP_INSERT) pos = POS_W'($urandom_range(list_len));
    else pos = (list_len == 0) ? '0 : POS_W'($urandom_range(list_len - 1));
    h = HANDLE_W'($urandom);
    r = $urandom_range(9);
    if (r < 3) k = $urandom_range(7);
    else if (r == 3) k = $urandom_range(1) ? '1 : '0;
    else if ((op == OP_FIND || op == OP_REMOVE_KEY) && list_len > 0 && r < 8)
      k = list_key[$urandom_range(list_len - 1)];
    else k = $urandom;
    return IN_TDATA_W'({k, h, pos, op});
  endfunction

  // Presents one operation from a falling edge and returns at the falling
  // edge after its transfer.
  task automatic send_op(input logic [IN_TDATA_W-1:0] word);
    int unsigned seen;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    seen = accept_cnt;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    while (accept_cnt == seen) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Scoreboard: check results first, then predict the operation taken at
  // this edge; a watchdog ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    list_result_t exp_res;
    list_result_t got_res;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got_res.ok     = m_tdata[0];
        got_res.handle = m_tdata[HANDLE_W:1];
        got_res.count  = m_tdata[HANDLE_W+CNT_W:HANDLE_W+1];
        if (pending_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          err_cnt++;
        end else begin
          exp_res = pending_results.pop_front();
          if (got_res.ok !== exp_res.ok) begin
            $error("ok: expected %0d, got %0d", exp_res.ok, got_res.ok);
            err_cnt++;
          end
          if (got_res.handle !== exp_res.handle) begin
            $error("found_handle: expected 0x%h, got 0x%h", exp_res.handle, got_res.handle);
            err_cnt++;
          end
          if (got_res.count !== exp_res.count) begin
            $error("entry_count: expected %0d, got %0d", exp_res.count, got_res.count);
            err_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        exp_res = apply_list_op(s_tdata[MODE_W-1:0], s_tdata[MODE_W+POS_W-1:MODE_W],
                                s_tdata[MODE_W+POS_W+HANDLE_W-1:MODE_W+POS_W],
                                s_tdata[IN_FIELDS_W-1:MODE_W+POS_W+HANDLE_W]);
        if (accept_cnt < DIR_N && op_table[accept_cnt].typed)
          exp_res = '{op_table[accept_cnt].ok, op_table[accept_cnt].fh,
                      op_table[accept_cnt].cnt};
        pending_results.push_back(exp_res);
        accept_cnt++;
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    int ph;
    int seg;
    int n;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (n = 0; n < DIR_N; n++) begin
      send_op(IN_TDATA_W'({op_table[n].key, op_table[n].handle, op_table[n].pos,
                           op_table[n].mode}));
    end

    // Phases: no idling, sender idle, receiver stall, both. Each phase runs
    // fill, balanced, drain and fill mixes so the full list is reached often.
    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct  = (ph == 1) ? 61 : ((ph == 3) ? 22 : 0);
      snk_stall_pct = (ph == 2) ? 61 : ((ph == 3) ? 22 : 0);
      for (seg = 0; seg < 4; seg++) begin
        for (n = 0; n < SEG_ITEMS; n++) send_op(make_random_op(seg == 3 ? 0 : seg));
      end
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
